### hw/rtl/mnvt_pkg.sv
package mnvt_pkg;

	localparam int VOICES    = 8;
	localparam int CHANNELS  = 16;
	localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W     = $clog2(VOICES + 1);
	localparam int TBL_DEPTH = CHANNELS * VOICES;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int CH_W      = 4;
	localparam int SLOT_W    = 3;
	localparam int VCNT_W    = 4;
	localparam int UNH_W     = 32;

	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_PROGRAM  = 4'hc;
	localparam logic [3:0] DRUM_RESET   = 4'd9;

	typedef enum logic [2:0] {
		EV_PENDING   = 3'd0,
		EV_ADDED     = 3'd1,
		EV_REMOVED   = 3'd2,
		EV_NOMATCH   = 3'd3,
		EV_FULL      = 3'd4,
		EV_DRUM      = 3'd5,
		EV_PROGRAM   = 3'd6,
		EV_UNHANDLED = 3'd7
	} ev_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_NEXT,
		RD_LAST
	} rd_sel_t;

	typedef enum logic [1:0] {
		EMIT_DEC,
		EMIT_REMOVED,
		EMIT_NOMATCH
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      decode;
		logic      rd;
		rd_sel_t   rd_sel;
		logic      idx_clr;
		logic      idx_inc;
		logic      move;
		logic      emit;
		emit_sel_t emit_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic search;
		logic match;
		logic idx_last;
	} dp_stat_t;

endpackage

### hw/rtl/midi_note_voice_tracker.sv
// channel   direction  handshake             fields
// command   in         start / busy          rx_byte
// config    in         cfg_valid / cfg_ready cfg_data (drum channel)
// result    out        done strobe           event_res channel note velocity slot
//                                            voice_count unhandled_total
// a byte is accepted in idle and decoded in the decode state; a note-off search then compares
// the slots one by one, at most 8, and adds a move state when a match is found; one note
// table read per cycle sets the pace of the search
// the result strobe rises in the cycle busy falls; start may be given then
// arst_n clears parse state, counters and voice counts; table contents stay undefined
// results cannot be held off: done is high for exactly one cycle per beat
module midi_note_voice_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output logic        done,
	output logic [2:0]  event_res,
	output logic [3:0]  channel,
	output logic [7:0]  note,
	output logic [7:0]  velocity,
	output logic [2:0]  slot,
	output logic [3:0]  voice_count,
	output logic [31:0] unhandled_total
);

	mnvt_pkg::dp_cmd_t  cmd;
	mnvt_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mnvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	mnvt_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx_byte),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.stat            (stat),
		.done            (done),
		.event_res       (event_res),
		.channel         (channel),
		.note            (note),
		.velocity        (velocity),
		.slot            (slot),
		.voice_count     (voice_count),
		.unhandled_total (unhandled_total)
	);

endmodule

### hw/rtl/mnvt_ctrl.sv
module mnvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mnvt_pkg::dp_stat_t  stat,
	output mnvt_pkg::dp_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CMP,
		ST_MOVE
	} state_t;

	state_t state_q;
	logic   busy_q;

	assign busy = busy_q;

	always_comb begin
		cmd = '0;
		cmd.rd_sel = mnvt_pkg::RD_FIRST;
		cmd.emit_sel = mnvt_pkg::EMIT_DEC;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.search) begin
					cmd.rd = 1'b1;
					cmd.rd_sel = mnvt_pkg::RD_FIRST;
					cmd.idx_clr = 1'b1;
				end else begin
					cmd.emit = 1'b1;
					cmd.emit_sel = mnvt_pkg::EMIT_DEC;
				end
			end
			ST_CMP: begin
				if (stat.match) begin
					cmd.rd = 1'b1;
					cmd.rd_sel = mnvt_pkg::RD_LAST;
				end else if (stat.idx_last) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = mnvt_pkg::EMIT_NOMATCH;
				end else begin
					// fetch the next slot while this one is compared
					cmd.rd = 1'b1;
					cmd.rd_sel = mnvt_pkg::RD_NEXT;
					cmd.idx_inc = 1'b1;
				end
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				cmd.emit = 1'b1;
				cmd.emit_sel = mnvt_pkg::EMIT_REMOVED;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECODE;
						busy_q <= 1'b1;
					end
				end
				ST_DECODE: begin
					if (stat.search) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_IDLE;
						busy_q <= 1'b0;
					end
				end
				ST_CMP: begin
					if (stat.match) begin
						state_q <= ST_MOVE;
					end else if (stat.idx_last) begin
						state_q <= ST_IDLE;
						busy_q <= 1'b0;
					end
				end
				ST_MOVE: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> state_q == ST_DECODE)
		else $error("accepted beat did not enter decode");

	a_emit_ends_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE && !busy_q)
		else $error("result emitted but controller still busy");

	a_move_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE |-> $past(state_q) == ST_CMP && $past(stat.match))
		else $error("move without a preceding match");

endmodule

### hw/rtl/mnvt_dpath.sv
module mnvt_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_valid,
	input  logic [3:0]          cfg_data,
	input  mnvt_pkg::dp_cmd_t   cmd,
	output mnvt_pkg::dp_stat_t  stat,
	output logic                done,
	output logic [2:0]          event_res,
	output logic [3:0]          channel,
	output logic [7:0]          note,
	output logic [7:0]          velocity,
	output logic [2:0]          slot,
	output logic [3:0]          voice_count,
	output logic [31:0]         unhandled_total
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA1,
		PH_DATA2,
		PH_PROG
	} ph_t;

	localparam int CW = mnvt_pkg::CNT_W;
	localparam int IW = mnvt_pkg::VIDX_W;
	localparam int AW = mnvt_pkg::TBL_AW;

	logic [7:0]    byte_q;
	ph_t           phase_q;
	logic [7:0]    run_q;
	logic [7:0]    cur_q;
	logic [7:0]    first_q;
	logic [31:0]   unh_q;
	logic [3:0]    drum_q;
	logic [CW-1:0] cnt_q [mnvt_pkg::CHANNELS];
	logic [CW-1:0] n_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    rdata_q;
	logic [7:0]    tbl_mem [mnvt_pkg::TBL_DEPTH];

	logic          done_q;
	mnvt_pkg::ev_t ev_q;
	logic [3:0]    ch_q;
	logic [7:0]    note_q;
	logic [7:0]    vel_q;
	logic [2:0]    slot_q;
	logic [3:0]    vcnt_q;
	logic [31:0]   unh_out_q;

	// decode of the current beat
	logic          is_status;
	logic [7:0]    cs;
	logic [3:0]    cur_ch;
	logic [CW-1:0] ch_cnt;
	ph_t           phase_d;
	logic [7:0]    run_d;
	logic [7:0]    cur_d;
	logic [7:0]    first_d;
	logic [31:0]   unh_d;
	mnvt_pkg::ev_t dec_ev;
	logic [3:0]    dec_ch;
	logic [7:0]    dec_nt;
	logic [7:0]    dec_vel;
	logic [2:0]    dec_slot;
	logic [CW-1:0] dec_cnt;
	logic          add;
	logic          search;
	logic          want_remove;

	logic [AW-1:0] base;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          wr_en;
	logic [CW-1:0] n_less;

	assign is_status = byte_q[7];
	assign cs = is_status ? byte_q : run_q;
	assign cur_ch = cur_q[3:0];
	assign ch_cnt = cnt_q[cur_ch];
	assign n_less = n_q - CW'(1);

	always_comb begin
		phase_d = phase_q;
		run_d = run_q;
		cur_d = cur_q;
		first_d = first_q;
		unh_d = unh_q;
		dec_ev = mnvt_pkg::EV_PENDING;
		dec_ch = cur_ch;
		dec_nt = 8'd0;
		dec_vel = 8'd0;
		dec_slot = 3'd0;
		add = 1'b0;
		search = 1'b0;
		want_remove = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				cur_d = cs;
				dec_ch = cs[3:0];
				if (cs[7:4] == mnvt_pkg::MSG_NOTE_OFF ||
						cs[7:4] == mnvt_pkg::MSG_NOTE_ON) begin
					if (is_status) begin
						phase_d = PH_DATA1;
					end else begin
						// data byte under running status
						first_d = byte_q;
						phase_d = PH_DATA2;
					end
				end else if (cs[7:4] == mnvt_pkg::MSG_PROGRAM) begin
					phase_d = PH_PROG;
				end else begin
					unh_d = unh_q + 32'd1;
					dec_ev = mnvt_pkg::EV_UNHANDLED;
				end
			end
			PH_DATA1: begin
				first_d = byte_q;
				phase_d = PH_DATA2;
			end
			PH_DATA2: begin
				dec_nt = first_q;
				dec_vel = byte_q;
				phase_d = PH_IDLE;
				if (cur_q[7:4] == mnvt_pkg::MSG_NOTE_ON) begin
					run_d = cur_q;
					if (cur_ch == drum_q) begin
						dec_ev = mnvt_pkg::EV_DRUM;
					end else if (byte_q != 8'd0) begin
						if (ch_cnt >= CW'(mnvt_pkg::VOICES)) begin
							dec_ev = mnvt_pkg::EV_FULL;
						end else begin
							dec_ev = mnvt_pkg::EV_ADDED;
							dec_slot = 3'(ch_cnt);
							add = 1'b1;
						end
					end else begin
						want_remove = 1'b1;
					end
				end else begin
					want_remove = 1'b1;
				end
				if (want_remove) begin
					if (ch_cnt == '0) begin
						dec_ev = mnvt_pkg::EV_NOMATCH;
					end else begin
						search = 1'b1;
					end
				end
			end
			PH_PROG: begin
				phase_d = PH_IDLE;
				dec_ev = mnvt_pkg::EV_PROGRAM;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		dec_cnt = add ? ch_cnt + CW'(1) : cnt_q[dec_ch];
	end

	assign stat.search = search;
	assign stat.match = (rdata_q == first_q);
	assign stat.idx_last = (idx_q == IW'(n_less));

	// note table addressing: one row of VOICES entries per channel
	assign base = AW'(cur_ch) * AW'(mnvt_pkg::VOICES);

	always_comb begin
		case (cmd.rd_sel)
			mnvt_pkg::RD_FIRST: rd_addr = base;
			mnvt_pkg::RD_NEXT:  rd_addr = base + AW'(idx_q) + AW'(1);
			mnvt_pkg::RD_LAST:  rd_addr = base + AW'(n_less);
			default:            rd_addr = base;
		endcase
	end

	assign wr_en = (cmd.decode && add) || cmd.move;
	assign wr_addr = cmd.move ? base + AW'(idx_q) : base + AW'(ch_cnt);
	assign wr_data = cmd.move ? rdata_q : first_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= tbl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= rx_byte;
		end
		if (cmd.decode) begin
			n_q <= ch_cnt;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			run_q <= 8'd0;
			cur_q <= 8'd0;
			first_q <= 8'd0;
			unh_q <= 32'd0;
			drum_q <= mnvt_pkg::DRUM_RESET;
			for (int i = 0; i < mnvt_pkg::CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				drum_q <= cfg_data;
			end
			if (cmd.decode) begin
				phase_q <= phase_d;
				run_q <= run_d;
				cur_q <= cur_d;
				first_q <= first_d;
				unh_q <= unh_d;
				if (add) begin
					cnt_q[cur_ch] <= ch_cnt + CW'(1);
				end
			end
			if (cmd.move) begin
				cnt_q[cur_ch] <= n_less;
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_sel)
				mnvt_pkg::EMIT_REMOVED: begin
					ev_q <= mnvt_pkg::EV_REMOVED;
					ch_q <= cur_ch;
					note_q <= first_q;
					vel_q <= byte_q;
					slot_q <= 3'(idx_q);
					vcnt_q <= 4'(n_less);
					unh_out_q <= unh_q;
				end
				mnvt_pkg::EMIT_NOMATCH: begin
					ev_q <= mnvt_pkg::EV_NOMATCH;
					ch_q <= cur_ch;
					note_q <= first_q;
					vel_q <= byte_q;
					slot_q <= 3'd0;
					vcnt_q <= 4'(n_q);
					unh_out_q <= unh_q;
				end
				default: begin
					ev_q <= dec_ev;
					ch_q <= dec_ch;
					note_q <= dec_nt;
					vel_q <= dec_vel;
					slot_q <= dec_slot;
					vcnt_q <= 4'(dec_cnt);
					unh_out_q <= unh_d;
				end
			endcase
		end
	end

	assign done = done_q;
	assign event_res = ev_q;
	assign channel = ch_q;
	assign note = note_q;
	assign velocity = vel_q;
	assign slot = slot_q;
	assign voice_count = vcnt_q;
	assign unhandled_total = unh_out_q;

	a_move_needs_entries: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> n_q != '0 && n_q <= CW'(mnvt_pkg::VOICES))
		else $error("remove with an empty voice list");

endmodule

### tb/midi_note_voice_tracker_checker.sv
module voice_tracker_checker
	import mnvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        done,
	input  logic [2:0]  event_res,
	input  logic [3:0]  channel,
	input  logic [7:0]  note,
	input  logic [7:0]  velocity,
	input  logic [2:0]  slot,
	input  logic [3:0]  voice_count,
	input  logic [31:0] unhandled_total,
	output int          fail_count,
	output int          pending_results
);

	typedef enum logic [1:0] {
		PARSE_IDLE,
		PARSE_DATA1,
		PARSE_DATA2,
		PARSE_PROG
	} parse_t;

	typedef struct packed {
		ev_t         ev;
		logic [3:0]  ch;
		logic [7:0]  note;
		logic [7:0]  vel;
		logic [2:0]  slot;
		logic [3:0]  vcount;
		logic [31:0] unh;
	} voice_result_t;

	logic [7:0]    note_tbl [CHANNELS][VOICES];
	logic [3:0]    voice_cnt [CHANNELS];
	logic [7:0]    run_status;
	logic [7:0]    cur_status;
	logic [7:0]    data1;
	parse_t        phase;
	logic [31:0]   unh_count;
	logic [3:0]    drum_ch;
	voice_result_t result_q [$];
	int            mismatches = 0;

	assign fail_count      = mismatches;
	assign pending_results = result_q.size();

	task automatic flag_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// first match is replaced by the last entry of the list
	task automatic drop_note(input logic [3:0] ch, input logic [7:0] nt,
			inout voice_result_t r);
		int n;
		int hit;
		n = voice_cnt[ch];
		if (n > VOICES)
			n = VOICES;
		hit = -1;
		for (int i = 0; i < n; i++)
			if (hit < 0 && note_tbl[ch][i] == nt)
				hit = i;
		if (hit < 0) begin
			r.ev = EV_NOMATCH;
		end else begin
			note_tbl[ch][hit] = note_tbl[ch][n - 1];
			voice_cnt[ch] = 4'(n - 1);
			r.slot = 3'(hit);
			r.ev = EV_REMOVED;
		end
	endtask

	task automatic add_note(input logic [3:0] ch, input logic [7:0] nt,
			inout voice_result_t r);
		int n;
		n = voice_cnt[ch];
		if (n >= VOICES) begin
			r.ev = EV_FULL;
		end else begin
			note_tbl[ch][n] = nt;
			voice_cnt[ch] = 4'(n + 1);
			r.slot = 3'(n);
			r.ev = EV_ADDED;
		end
	endtask

	task automatic track_byte(input logic [7:0] b, output voice_result_t r);
		logic [3:0] cmd;
		logic [3:0] ch;
		r = '0;
		r.ev = EV_PENDING;
		case (phase)
			PARSE_IDLE: begin
				cur_status = b[7] ? b : run_status;
				cmd = cur_status[7:4];
				if (cmd == MSG_NOTE_OFF || cmd == MSG_NOTE_ON) begin
					if (b[7]) begin
						phase = PARSE_DATA1;
					end else begin
						data1 = b;
						phase = PARSE_DATA2;
					end
				end else if (cmd == MSG_PROGRAM) begin
					phase = PARSE_PROG;
				end else begin
					unh_count = unh_count + 32'd1;
					r.ev = EV_UNHANDLED;
				end
			end
			PARSE_DATA1: begin
				data1 = b;
				phase = PARSE_DATA2;
			end
			PARSE_DATA2: begin
				ch = cur_status[3:0];
				cmd = cur_status[7:4];
				r.note = data1;
				r.vel = b;
				phase = PARSE_IDLE;
				if (cmd == MSG_NOTE_ON) begin
					// only note-on sets the running status, drum channel included
					run_status = cur_status;
					if (ch == drum_ch)
						r.ev = EV_DRUM;
					else if (b != 8'd0)
						add_note(ch, data1, r);
					else
						drop_note(ch, data1, r);
				end else begin
					drop_note(ch, data1, r);
				end
			end
			default: begin
				phase = PARSE_IDLE;
				r.ev = EV_PROGRAM;
			end
		endcase
		ch = cur_status[3:0];
		r.ch = ch;
		r.vcount = voice_cnt[ch];
		r.unh = unh_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		voice_result_t got;
		voice_result_t want;
		voice_result_t fresh;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				voice_cnt[c] = '0;
				for (int v = 0; v < VOICES; v++)
					note_tbl[c][v] = '0;
			end
			run_status = '0;
			cur_status = '0;
			data1 = '0;
			phase = PARSE_IDLE;
			unh_count = '0;
			drum_ch = DRUM_RESET;
			result_q.delete();
		end else begin
			// retire before predicting: a new beat may land on the edge of the last strobe
			if (done) begin
				got.ev = ev_t'(event_res);
				got.ch = channel;
				got.note = note;
				got.vel = velocity;
				got.slot = slot;
				got.vcount = voice_count;
				got.unh = unhandled_total;
				if (result_q.size() == 0) begin
					flag_failure($sformatf({"unexpected result: ev=%0d ch=%0d ",
						"note=%02h vel=%02h slot=%0d cnt=%0d unh=%0d"},
						got.ev, got.ch, got.note, got.vel, got.slot, got.vcount, got.unh));
				end else begin
					want = result_q.pop_front();
					if (got !== want)
						flag_failure($sformatf({"result mismatch: expected ev=%0d ch=%0d ",
							"note=%02h vel=%02h slot=%0d cnt=%0d unh=%0d, got ev=%0d ch=%0d ",
							"note=%02h vel=%02h slot=%0d cnt=%0d unh=%0d"},
							want.ev, want.ch, want.note, want.vel, want.slot, want.vcount,
							want.unh, got.ev, got.ch, got.note, got.vel, got.slot,
							got.vcount, got.unh));
				end
			end
			if (cfg_valid && cfg_ready)
				drum_ch = cfg_data;
			if (start && !busy) begin
				track_byte(rx_byte, fresh);
				result_q.push_back(fresh);
			end
		end
	end

endmodule

### tb/testbench.sv
module testbench;
	import mnvt_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          PHASE_BYTES = 160;
	localparam logic [7:0]  SYS_RESET   = 8'hff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_valid = 1'b0;
	logic [3:0]  cfg_data = 4'd0;
	logic        busy;
	logic        cfg_ready;
	logic        done;
	logic [2:0]  event_res;
	logic [3:0]  channel;
	logic [7:0]  note;
	logic [7:0]  velocity;
	logic [2:0]  slot;
	logic [3:0]  voice_count;
	logic [31:0] unhandled_total;
	int          fail_count;
	int          pending_results;

	int          cycle_count = 0;
	logic [7:0]  tx_bytes [$];
	int          burst_left = 0;
	bit          steady = 1'b0;
	logic [3:0]  drum_now = DRUM_RESET;
	logic [7:0]  note_pool [8];

	midi_note_voice_tracker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.rx_byte        (rx_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.event_res      (event_res),
		.channel        (channel),
		.note           (note),
		.velocity       (velocity),
		.slot           (slot),
		.voice_count    (voice_count),
		.unhandled_total(unhandled_total)
	);

	voice_tracker_checker voice_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.rx_byte        (rx_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.event_res      (event_res),
		.channel        (channel),
		.note           (note),
		.velocity       (velocity),
		.slot           (slot),
		.voice_count    (voice_count),
		.unhandled_total(unhandled_total),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("midi_note_voice_tracker regression: fail");
			$finish;
		end
	end

	// one beat; start stays high so back-to-back bytes need no extra edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic flush_bytes();
		while (tx_bytes.size() > 0)
			send_byte(tx_bytes.pop_front());
		start <= 1'b0;
	endtask

	task automatic settle(input int tail);
		do @(negedge clk); while (pending_results != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_drum(input logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		drum_now = v;
	endtask

	// three busy channels (0 to 2) so lists fill up, plus the drum channel and now and then any channel
	function automatic logic [3:0] pick_channel();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5)
			return 4'($urandom_range(0, 2));
		else if (r <= 7)
			return drum_now;
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [7:0] pick_note();
		if ($urandom_range(0, 99) < 85)
			return note_pool[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_velocity();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		else if (r == 1)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(1, 127));
	endfunction

	task automatic queue_message();
		int r;
		logic [3:0] hi;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			tx_bytes.push_back({MSG_NOTE_ON, pick_channel()});
			tx_bytes.push_back(pick_note());
			tx_bytes.push_back(pick_velocity());
		end else if (r < 65) begin
			// running status pair
			tx_bytes.push_back(pick_note() & 8'h7f);
			tx_bytes.push_back(pick_velocity());
		end else if (r < 80) begin
			tx_bytes.push_back({MSG_NOTE_OFF, pick_channel()});
			tx_bytes.push_back(pick_note());
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (r < 87) begin
			tx_bytes.push_back({MSG_PROGRAM, 4'($urandom_range(0, 15))});
			tx_bytes.push_back(8'($urandom_range(0, 127)));
		end else if (r < 93) begin
			do hi = 4'($urandom_range(8, 15));
			while (hi == MSG_NOTE_OFF || hi == MSG_NOTE_ON || hi == MSG_PROGRAM);
			tx_bytes.push_back({hi, 4'($urandom_range(0, 15))});
			tx_bytes.push_back(8'($urandom_range(0, 127)));
		end else begin
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [3:0] drum_plan [4];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_drum(DRUM_RESET);

		tx_bytes = {
			8'h00,
			{MSG_NOTE_ON, 4'd0}, 8'h3c, 8'h7f,
			8'h3e, 8'h40,
			8'h3c, 8'h00,
			{MSG_NOTE_OFF, 4'd0}, 8'h3e, 8'h01,
			{MSG_NOTE_OFF, 4'd15}, 8'h11, 8'h22,
			{MSG_NOTE_ON, DRUM_RESET}, 8'h24, 8'h7f,
			{MSG_PROGRAM, 4'd5}, 8'h07,
			// running status is the drum note-on now, so velocity zero is ignored too
			8'h7f, 8'h00,
			SYS_RESET,
			{MSG_NOTE_ON, 4'd0}, 8'h95, 8'hff
		};
		flush_bytes();
		settle(4);

		drum_plan[0] = 4'd0;
		drum_plan[1] = 4'd15;
		drum_plan[2] = 4'($urandom_range(0, 15));
		drum_plan[3] = 4'($urandom_range(0, 15));
		for (int p = 0; p < 4; p++) begin
			write_drum(drum_plan[p]);
			for (int k = 0; k < 8; k++)
				note_pool[k] = 8'($urandom_range(0, 127));
			steady = (p == 1);
			burst_left = 0;
			while (tx_bytes.size() < PHASE_BYTES)
				queue_message();
			flush_bytes();
			settle(4);
		end

		settle(20);
		if (fail_count == 0)
			$display("midi_note_voice_tracker regression: pass");
		else
			$display("midi_note_voice_tracker regression: fail");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mnvt_pkg.sv
hw/rtl/mnvt_ctrl.sv
hw/rtl/mnvt_dpath.sv
hw/rtl/midi_note_voice_tracker.sv
tb/midi_note_voice_tracker_checker.sv
tb/testbench.sv
